[rtl/core/vid_pkg.sv]
package vid_pkg;

  // input item
  typedef struct packed {
    logic signed [31:0] position;
    logic signed [15:0] deviation;
    logic        [15:0] slope_magnitude;
    logic        [8:0]  segment_speed;
  } in_item_t;

  // result item
  typedef struct packed {
    logic signed [31:0] segment_start;
    logic signed [31:0] segment_end;
    logic signed [31:0] peak_position;
    logic signed [15:0] peak_value;
    logic        [15:0] peak_slope;
    logic               severity;
  } out_item_t;

  // grading outcome
  typedef struct packed {
    logic hit;
    logic severe;
  } grade_t;

  // sign codes of a deviation sample
  localparam logic [1:0] SIGN_ZERO = 2'd0;
  localparam logic [1:0] SIGN_POS  = 2'd1;
  localparam logic [1:0] SIGN_NEG  = 2'd2;

  // severity codes
  localparam logic SEV_WARNING = 1'b0;
  localparam logic SEV_SEVERE  = 1'b1;

  // speed bands in km/h
  localparam logic [8:0] SPD_A_LO = 9'd141;
  localparam logic [8:0] SPD_A_HI = 9'd160;
  localparam logic [8:0] SPD_B_HI = 9'd200;
  localparam logic [8:0] SPD_C_HI = 9'd250;

  // length bands in cm
  localparam logic [32:0] LEN_B_SHORT = 33'd10000;
  localparam logic [32:0] LEN_C_SHORT = 33'd15000;

  // value bands in tenths of mm
  localparam logic [16:0] VAL_30  = 17'd300;
  localparam logic [16:0] VAL_35  = 17'd350;
  localparam logic [16:0] VAL_40  = 17'd400;
  localparam logic [16:0] VAL_50  = 17'd500;
  localparam logic [16:0] VAL_60  = 17'd600;
  localparam logic [16:0] VAL_70  = 17'd700;
  localparam logic [16:0] VAL_90  = 17'd900;
  localparam logic [16:0] VAL_100 = 17'd1000;

  // sign of a deviation sample
  function automatic logic [1:0] sign_of(input logic signed [15:0] v);
    logic [1:0] s;
    if (v > 16'sd0) s = SIGN_POS;
    else if (v < 16'sd0) s = SIGN_NEG;
    else s = SIGN_ZERO;
    return s;
  endfunction

  // grade a magnitude against speed and length bands
  function automatic grade_t grade(input logic [8:0] speed, input logic [32:0] len,
                                   input logic [16:0] m);
    grade_t g;
    logic [16:0] warn;
    logic [16:0] sev;
    logic in_band;
    warn = VAL_40;
    sev = VAL_70;
    in_band = 1'b1;
    if (speed >= SPD_A_LO && speed <= SPD_A_HI) begin
      warn = VAL_40;
      sev = VAL_70;
    end else if (speed > SPD_A_HI && speed <= SPD_B_HI) begin
      if (len < LEN_B_SHORT) begin
        warn = VAL_30;
        sev = VAL_60;
      end else begin
        warn = VAL_40;
        sev = VAL_90;
      end
    end else if (speed > SPD_B_HI && speed <= SPD_C_HI) begin
      if (len < LEN_C_SHORT) begin
        warn = VAL_35;
        sev = VAL_70;
      end else begin
        warn = VAL_50;
        sev = VAL_100;
      end
    end else begin
      in_band = 1'b0;
    end
    g.hit = in_band && (m >= warn);
    g.severe = (m >= sev) ? SEV_SEVERE : SEV_WARNING;
    return g;
  endfunction

endpackage

[rtl/core/vid_tracker.sv]
module vid_tracker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  vid_pkg::in_item_t item,
  output logic              res_hit,
  output vid_pkg::out_item_t res
);

  logic signed [31:0] seg_begin_r, seg_begin_nxt;
  logic signed [15:0] run_min_r, run_min_nxt;
  logic signed [15:0] run_max_r, run_max_nxt;
  logic signed [31:0] min_at_r, min_at_nxt;
  logic signed [31:0] max_at_r, max_at_nxt;
  logic signed [15:0] prev_min_r, prev_min_nxt;
  logic signed [15:0] prev_max_r, prev_max_nxt;
  logic        [15:0] slope_max_r, slope_max_nxt;
  logic        [1:0]  prev_sign_r, prev_sign_nxt;
  logic               first_r, first_nxt;

  logic signed [31:0] base_begin;
  logic signed [15:0] rmin, rmax;
  logic        [15:0] rslope;
  logic        [1:0]  sgn;
  logic signed [32:0] diff;
  logic        [32:0] len;
  logic        [16:0] mag_min, mag_max;
  logic               pick_min;
  logic signed [15:0] pv;
  logic signed [31:0] pp;
  vid_pkg::grade_t    g;
  logic               closing;

  // running extremes including this item
  always_comb begin
    base_begin = first_r ? item.position : seg_begin_r;
    rmin = (item.deviation < run_min_r) ? item.deviation : run_min_r;
    rmax = (item.deviation > run_max_r) ? item.deviation : run_max_r;
    rslope = (item.slope_magnitude > slope_max_r) ? item.slope_magnitude : slope_max_r;
    sgn = vid_pkg::sign_of(item.deviation);
    min_at_nxt = first_r ? item.position :
                 ((rmin != prev_min_r) ? item.position : min_at_r);
    max_at_nxt = first_r ? item.position :
                 ((rmax != prev_max_r) ? item.position : max_at_r);
    closing = !first_r && (sgn != prev_sign_r);
  end

  // close-out: pick extreme, length and grade
  always_comb begin
    diff = {item.position[31], item.position} - {base_begin[31], base_begin};
    len = diff[32] ? (33'd0 - diff) : diff;
    mag_min = 17'd0 - {rmin[15], rmin};
    mag_max = {1'b0, rmax};
    pick_min = mag_min > mag_max;
    pv = pick_min ? rmin : rmax;
    pp = pick_min ? min_at_nxt : max_at_nxt;
    g = vid_pkg::grade(item.segment_speed, len, pick_min ? mag_min : mag_max);
    res_hit = closing && g.hit;
    res.segment_start = base_begin;
    res.segment_end = item.position;
    res.peak_position = pp;
    res.peak_value = pv;
    res.peak_slope = rslope;
    res.severity = g.severe;
  end

  // next segment state
  always_comb begin
    prev_min_nxt = rmin;
    prev_max_nxt = rmax;
    first_nxt = 1'b0;
    prev_sign_nxt = (first_r || closing) ? sgn : prev_sign_r;
    if (closing) begin
      run_min_nxt = 16'sd0;
      run_max_nxt = 16'sd0;
      slope_max_nxt = 16'd0;
      seg_begin_nxt = item.position;
    end else begin
      run_min_nxt = rmin;
      run_max_nxt = rmax;
      slope_max_nxt = rslope;
      seg_begin_nxt = base_begin;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_begin_r <= '0;
      run_min_r <= '0;
      run_max_r <= '0;
      min_at_r <= '0;
      max_at_r <= '0;
      prev_min_r <= '0;
      prev_max_r <= '0;
      slope_max_r <= '0;
      prev_sign_r <= vid_pkg::SIGN_ZERO;
      first_r <= 1'b1;
    end else if (step_en) begin
      seg_begin_r <= seg_begin_nxt;
      run_min_r <= run_min_nxt;
      run_max_r <= run_max_nxt;
      min_at_r <= min_at_nxt;
      max_at_r <= max_at_nxt;
      prev_min_r <= prev_min_nxt;
      prev_max_r <= prev_max_nxt;
      slope_max_r <= slope_max_nxt;
      prev_sign_r <= prev_sign_nxt;
      first_r <= first_nxt;
    end
  end

endmodule

[rtl/core/vertical_irregularity_detector.sv]
// an accepted item is held in the input register, and any result it yields in the result register
// throughput: 1 item per cycle unless out_stall holds a full result register, set by the segment state update
// the input register refills in the cycle it drains, so stall follows out_stall
// reset: synchronous active-low rst_n clears valids and segment state,
// the next item is taken as the first sample
module vertical_irregularity_detector (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  vid_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output vid_pkg::out_item_t out_data
);

  logic               in_valid_r;
  vid_pkg::in_item_t  in_item_r;
  logic               out_valid_r;
  vid_pkg::out_item_t out_item_r;
  logic               advance;
  logic               res_hit;
  vid_pkg::out_item_t res;

  // stage advances when the result register is free or drains now
  assign advance = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_data;
    end
  end

  vid_tracker u_tracker (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (in_item_r),
    .res_hit (res_hit),
    .res     (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= advance && res_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_hit) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_item_r;

endmodule
